>>> sv/fixed_block_pool_allocator_top_defines.svh
// assertion macros used by fixed_block_pool_allocator_top
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FBPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define FBPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/fbpa_pkg.sv
package fbpa_pkg;

  // pool limits
  localparam int MAX_BLOCKS  = 256;
  localparam int MAX_WAITERS = 255;

  // field widths
  localparam int BLK_W   = 8;
  localparam int CNT_W   = 9;
  localparam int WAIT_W  = 8;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;

  // link value meaning end of list
  localparam logic [CNT_W-1:0] END_MARK = CNT_W'(MAX_BLOCKS);

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC    = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE     = 3'd1;
  localparam logic [OP_W-1:0] OP_FORMAT   = 3'd2;
  localparam logic [OP_W-1:0] OP_GIVE_UP  = 3'd3;
  localparam logic [OP_W-1:0] OP_WAKE_ALL = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_QUEUED = 2'd2;
  localparam logic [STAT_W-1:0] ST_DONE   = 2'd3;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_FORMAT
  } state_t;

  // one result beat
  typedef struct packed {
    logic [WAIT_W-1:0] woken;
    logic [WAIT_W-1:0] waiters;
    logic [CNT_W-1:0]  free_blocks;
    logic [BLK_W-1:0]  granted_block;
    logic [STAT_W-1:0] status;
  } res_t;

  // block count clamped to 1..MAX_BLOCKS
  function automatic logic [CNT_W-1:0] pool_size(input logic [CNT_W-1:0] bc);
    logic [CNT_W-1:0] n;
    n = bc;
    if (bc == '0) n = CNT_W'(1);
    else if (bc > CNT_W'(MAX_BLOCKS)) n = CNT_W'(MAX_BLOCKS);
    return n;
  endfunction

endpackage

>>> sv/fbpa_out_buf.sv
module fbpa_out_buf
  import fbpa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic ready,
  output logic m_valid,
  input  logic m_ready,
  output res_t m_data
);

  logic out_valid;
  res_t out_data;
  logic sk_valid;
  res_t sk_data;
  logic take;

  assign take    = out_valid && m_ready;
  assign ready   = !sk_valid;
  assign m_valid = out_valid;
  assign m_data  = out_data;

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (!out_valid || take) begin
      if (sk_valid) begin
        out_valid <= 1'b1;
        out_data  <= sk_data;
        sk_valid  <= push;
        if (push) sk_data <= push_data;
      end else begin
        out_valid <= push;
        if (push) out_data <= push_data;
      end
    end else if (push) begin
      sk_valid <= 1'b1;
      sk_data  <= push_data;
    end
  end

endmodule

>>> sv/fixed_block_pool_allocator_top.sv
// Fixed-size block pool allocator: blocks are indices kept on a linked free list.
// Input channel s_*: one beat is one request (alloc, free, format, give up,
// wake all). Output channel m_*: exactly one result beat per request, in order.
// cfg_*: block_count write, always ready; write it only while the block is idle.
// Work per request, from accept to result in the output register:
//   alloc with a free block: one link-store read through the registered read port (S_ALLOC_RD)
//   free, give up, wake all, reserved codes, alloc on an empty pool: result pushed at accept
//   format: one link-store entry written per cycle over the whole pool (S_FORMAT)
// One request is worked on at a time; the next is taken once it is done.
// The output register has a skid entry behind it, so one more request is
// accepted and finished while a result stalls; beyond that s_tready drops
// until the receiver takes a beat.
// Reset: list empty (head at end marker), free and waiter counts zero,
// block_count 256. The link store holds nothing valid until the first format.
// The block is ready right out of reset; no clearing pass.
`include "fixed_block_pool_allocator_top_defines.svh"

module fixed_block_pool_allocator_top
  import fbpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [0] may_wait, [8:1] block_index, rest zero
  input  logic [2:0]  s_tuser,   // [2:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] granted_block, [16:8] free_blocks,
                                 // [24:17] waiters, [32:25] woken, rest zero
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data   // [8:0] block_count
);

  // link store
  logic [CNT_W-1:0] link_mem [MAX_BLOCKS];
  logic             mem_we;
  logic [BLK_W-1:0] mem_waddr;
  logic [CNT_W-1:0] mem_wdata;
  logic [CNT_W-1:0] rd_data;

  // pool registers
  state_t            state, state_next;
  logic [CNT_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  free_cnt, free_cnt_next;
  logic [WAIT_W-1:0] wait_cnt, wait_cnt_next;
  logic [CNT_W-1:0]  block_count;
  logic [BLK_W-1:0]  fmt_cnt, fmt_cnt_next;

  // request fields
  logic [OP_W-1:0]  op;
  logic             may_wait;
  logic [BLK_W-1:0] blk;
  logic             acc;
  logic             buf_ready;
  logic             pool_empty;
  logic [CNT_W-1:0] n_blocks;
  logic [CNT_W-1:0] fmt_nxt;
  logic             fmt_last;

  // result path
  logic res_push;
  res_t res;
  res_t m_res;

  assign op       = s_tuser;
  assign may_wait = s_tdata[0];
  assign blk      = s_tdata[8:1];

  assign cfg_ready  = 1'b1;
  assign s_tready   = (state == S_IDLE) && buf_ready;
  assign acc        = s_tvalid && s_tready;
  assign pool_empty = (free_cnt == '0) || head[CNT_W-1];
  assign n_blocks   = pool_size(block_count);
  assign fmt_nxt    = {1'b0, fmt_cnt} + CNT_W'(1);
  assign fmt_last   = (fmt_nxt == n_blocks);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc && op == OP_ALLOC && !pool_empty) state_next = S_ALLOC_RD;
        else if (acc && op == OP_FORMAT) state_next = S_FORMAT;
      end
      S_ALLOC_RD: state_next = S_IDLE;
      S_FORMAT: begin
        if (fmt_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and result per state
  always_comb begin
    head_next     = head;
    free_cnt_next = free_cnt;
    wait_cnt_next = wait_cnt;
    fmt_cnt_next  = fmt_cnt;
    mem_we        = 1'b0;
    mem_waddr     = blk;
    mem_wdata     = head;
    res_push      = 1'b0;
    res.status        = ST_DONE;
    res.granted_block = '0;
    res.woken         = '0;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          unique case (op)
            OP_ALLOC: begin
              if (pool_empty) begin
                res_push = 1'b1;
                if (may_wait && wait_cnt < WAIT_W'(MAX_WAITERS)) begin
                  wait_cnt_next = wait_cnt + WAIT_W'(1);
                  res.status    = ST_QUEUED;
                end else begin
                  res.status = ST_EMPTY;
                end
              end
            end
            OP_FREE: begin
              res_push = 1'b1;
              if ({1'b0, blk} < n_blocks) begin
                mem_we    = 1'b1;
                head_next = {1'b0, blk};
                if (free_cnt < CNT_W'(MAX_BLOCKS)) free_cnt_next = free_cnt + CNT_W'(1);
                if (wait_cnt != '0) begin
                  wait_cnt_next = wait_cnt - WAIT_W'(1);
                  res.woken     = WAIT_W'(1);
                end
              end
            end
            OP_FORMAT: fmt_cnt_next = '0;
            OP_GIVE_UP: begin
              res_push = 1'b1;
              if (wait_cnt != '0) wait_cnt_next = wait_cnt - WAIT_W'(1);
            end
            OP_WAKE_ALL: begin
              res_push      = 1'b1;
              res.woken     = wait_cnt;
              wait_cnt_next = '0;
            end
            default: res_push = 1'b1;
          endcase
        end
      end
      S_ALLOC_RD: begin
        // link of the old head came back from the store
        res_push          = 1'b1;
        res.status        = ST_OK;
        res.granted_block = head[BLK_W-1:0];
        head_next         = rd_data;
        free_cnt_next     = free_cnt - CNT_W'(1);
      end
      S_FORMAT: begin
        mem_we       = 1'b1;
        mem_waddr    = fmt_cnt;
        mem_wdata    = fmt_last ? END_MARK : fmt_nxt;
        fmt_cnt_next = fmt_nxt[BLK_W-1:0];
        if (fmt_last) begin
          res_push      = 1'b1;
          head_next     = '0;
          free_cnt_next = n_blocks;
          wait_cnt_next = '0;
        end
      end
      default: ;
    endcase
    res.free_blocks = free_cnt_next;
    res.waiters     = wait_cnt_next;
  end

  // control and pool registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= END_MARK;
      free_cnt    <= '0;
      wait_cnt    <= '0;
      block_count <= CNT_W'(MAX_BLOCKS);
      fmt_cnt     <= '0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      free_cnt <= free_cnt_next;
      wait_cnt <= wait_cnt_next;
      fmt_cnt  <= fmt_cnt_next;
      if (cfg_valid && cfg_ready) block_count <= cfg_data;
    end
  end

  // link store: one write port, read at the head
  always_ff @(posedge clk) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
    rd_data <= link_mem[head[BLK_W-1:0]];
  end

  // result buffer
  fbpa_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .ready     (buf_ready),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_data    (m_res)
  );

  assign m_tuser = m_res.status;
  assign m_tdata = {7'd0, m_res.woken, m_res.waiters, m_res.free_blocks, m_res.granted_block};

  // checks
  `FBPA_ASSERT_NEXT(a_alloc_reads, acc && op == OP_ALLOC && !pool_empty,
                    state == S_ALLOC_RD, "alloc with free block did not read the link store")
  `FBPA_ASSERT_NOW(a_alloc_result, state == S_ALLOC_RD, res_push && !head[CNT_W-1],
                   "alloc read without a grant")
  `FBPA_ASSERT_NOW(a_skid_free, state != S_IDLE, buf_ready,
                   "skid entry filled while a request is in progress")
  `FBPA_ASSERT_NOW(a_free_limit, 1'b1, free_cnt <= CNT_W'(MAX_BLOCKS),
                   "free count above pool limit")

endmodule

>>> verif/fixed_block_pool_allocator_top_tb.sv
`timescale 1ns / 100ps

module fixed_block_pool_allocator_top_tb;
  import fbpa_pkg::*;

  // operation codes the block does not define, must leave the pool untouched
  localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [0] may_wait, [8:1] block_index, rest zero
  logic [2:0]  s_tuser = '0;   // [2:0] operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [7:0] granted, [16:8] free, [24:17] waiters, [32:25] woken
  logic [1:0]  m_tuser;        // [1:0] status
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;  // [8:0] block_count

  // predicted pool state
  logic [CNT_W-1:0]  free_link [MAX_BLOCKS] = '{default: '0};
  logic [CNT_W-1:0]  list_head = END_MARK;
  logic [CNT_W-1:0]  free_total = '0;
  logic [WAIT_W-1:0] waiting = '0;
  logic [CNT_W-1:0]  pool_blocks = 9'd256;

  // expected result beats, oldest first
  res_t pending_results [$];
  int   granted_blocks [$];
  int   owed_allocs = 0;
  int   mismatch_count = 0;

  // receiver control
  int   sink_hold = 0;
  bit   steady = 1'b0;

  always #1 clk = ~clk;

  fixed_block_pool_allocator_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // block count as format uses it
  function automatic logic [CNT_W-1:0] clamp_block_count(input logic [CNT_W-1:0] v);
    if (v == '0) return CNT_W'(1);
    if (v > CNT_W'(MAX_BLOCKS)) return CNT_W'(MAX_BLOCKS);
    return v;
  endfunction

  // advance the predicted pool by one request and return its result beat
  function automatic res_t predict_pool_result(input logic [OP_W-1:0] op,
                                               input logic wait_ok,
                                               input logic [BLK_W-1:0] blk);
    res_t r;
    logic [CNT_W-1:0] n;
    r = '0;
    r.status = ST_DONE;
    n = clamp_block_count(pool_blocks);
    case (op)
      OP_ALLOC: begin
        // a head at the end marker means empty whatever the count says
        if (free_total == '0 || list_head >= END_MARK) begin
          if (wait_ok && waiting < MAX_WAITERS) begin
            waiting = waiting + 1'b1;
            r.status = ST_QUEUED;
          end else begin
            r.status = ST_EMPTY;
          end
        end else begin
          r.granted_block = list_head[BLK_W-1:0];
          list_head = free_link[list_head[BLK_W-1:0]];
          free_total = free_total - 1'b1;
          r.status = ST_OK;
        end
      end
      OP_FREE: begin
        // out-of-pool index is dropped, double free is pushed again
        if ({1'b0, blk} < n) begin
          free_link[blk] = list_head;
          list_head = {1'b0, blk};
          if (free_total < CNT_W'(MAX_BLOCKS)) free_total = free_total + 1'b1;
          if (waiting != '0) begin
            waiting = waiting - 1'b1;
            r.woken = 8'd1;
          end
        end
      end
      OP_FORMAT: begin
        for (int i = 0; i < MAX_BLOCKS; i++) begin
          if (i < n) free_link[i] = (i + 1 < n) ? CNT_W'(i + 1) : END_MARK;
        end
        list_head = '0;
        free_total = n;
        waiting = '0;
      end
      OP_GIVE_UP: begin
        if (waiting != '0) waiting = waiting - 1'b1;
      end
      OP_WAKE_ALL: begin
        r.woken = waiting;
        waiting = '0;
      end
      default: ;
    endcase
    r.free_blocks = free_total;
    r.waiters = waiting;
    return r;
  endfunction

  // send one request beat, then record its expected result
  task automatic send_request(input logic [OP_W-1:0] op, input logic wait_ok,
                              input logic [BLK_W-1:0] blk);
    logic hs;
    res_t exp_res;
    if (!steady && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'b0, blk, wait_ok};
    do begin
      @(negedge clk);
      hs = s_tready;
      @(posedge clk);
    end while (!hs);
    exp_res = predict_pool_result(op, wait_ok, blk);
    pending_results.push_back(exp_res);
    if (op == OP_ALLOC && exp_res.status == ST_OK)
      granted_blocks.push_back(int'(exp_res.granted_block));
    if (op == OP_FORMAT) granted_blocks.delete();
    if (op == OP_FREE && exp_res.woken != '0) owed_allocs++;
  endtask

  // stop sending and wait until every expected beat has come back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // block_count write, only called while the pool is idle
  task automatic write_block_count(input logic [CNT_W-1:0] v);
    logic hs;
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do begin
      @(negedge clk);
      hs = cfg_ready;
      @(posedge clk);
    end while (!hs);
    cfg_valid <= 1'b0;
    pool_blocks = v;
  endtask

  // one random request, weighted toward well-formed alloc/free traffic
  task automatic send_random_item();
    int pick;
    int idx;
    logic [OP_W-1:0] op;
    pick = $urandom_range(0, 99);
    if (owed_allocs > 0 && $urandom_range(0, 1) == 0) begin
      // woken requester comes back for its block
      owed_allocs--;
      send_request(OP_ALLOC, 1'b1, 8'($urandom));
    end else if (pick < 40) begin
      send_request(OP_ALLOC, 1'($urandom), 8'($urandom));
    end else if (pick < 70 && granted_blocks.size() != 0) begin
      idx = $urandom_range(0, granted_blocks.size() - 1);
      op = OP_FREE;
      send_request(op, 1'($urandom), 8'(granted_blocks[idx]));
      granted_blocks.delete(idx);
    end else if (pick < 80) begin
      send_request(OP_FREE, 1'($urandom), 8'($urandom));
    end else if (pick < 87) begin
      send_request(OP_GIVE_UP, 1'($urandom), 8'($urandom));
    end else if (pick < 93) begin
      send_request(OP_WAKE_ALL, 1'($urandom), 8'($urandom));
    end else if (pick < 96) begin
      send_request(OP_FORMAT, 1'($urandom), 8'($urandom));
    end else begin
      case ($urandom_range(0, 2))
        0:       op = OP_RSVD_5;
        1:       op = OP_RSVD_6;
        default: op = OP_RSVD_7;
      endcase
      send_request(op, 1'($urandom), 8'($urandom));
    end
  endtask

  // list still empty after reset: waiters, frees and allocs before any format
  task automatic test_unformatted_pool();
    send_request(OP_ALLOC, 1'b0, 8'd0);
    send_request(OP_ALLOC, 1'b1, 8'd255);
    send_request(OP_GIVE_UP, 1'b0, 8'd0);
    send_request(OP_GIVE_UP, 1'b1, 8'd0);
    send_request(OP_WAKE_ALL, 1'b0, 8'd0);
    send_request(OP_ALLOC, 1'b1, 8'd0);
    send_request(OP_FREE, 1'b0, 8'd255);
    send_request(OP_ALLOC, 1'b1, 8'd0);
    send_request(OP_RSVD_5, 1'b1, 8'd255);
    send_request(OP_RSVD_6, 1'b0, 8'd0);
    send_request(OP_RSVD_7, 1'b1, 8'd170);
  endtask

  // smallest and largest pools, out-of-pool free, double free saturation
  task automatic test_format_limits();
    wait_for_results();
    write_block_count(9'd0);
    send_request(OP_FORMAT, 1'b0, 8'd0);
    send_request(OP_ALLOC, 1'b0, 8'd0);
    send_request(OP_ALLOC, 1'b0, 8'd0);
    send_request(OP_ALLOC, 1'b1, 8'd0);
    send_request(OP_ALLOC, 1'b1, 8'd0);
    send_request(OP_FREE, 1'b0, 8'd1);
    send_request(OP_FREE, 1'b0, 8'd0);
    send_request(OP_WAKE_ALL, 1'b0, 8'd0);
    wait_for_results();
    write_block_count(9'd511);
    send_request(OP_FORMAT, 1'b1, 8'd255);
    send_request(OP_FREE, 1'b0, 8'd255);
    send_request(OP_ALLOC, 1'b0, 8'd0);
    send_request(OP_ALLOC, 1'b1, 8'd0);
  endtask

  // fill the waiter count to its ceiling, then release everyone at once
  task automatic test_waiter_limit();
    wait_for_results();
    write_block_count(9'd1);
    send_request(OP_FORMAT, 1'b0, 8'd0);
    send_request(OP_ALLOC, 1'b0, 8'd0);
    repeat (MAX_WAITERS + 2) send_request(OP_ALLOC, 1'b1, 8'($urandom));
    send_request(OP_GIVE_UP, 1'b0, 8'd0);
    send_request(OP_ALLOC, 1'b1, 8'd0);
    send_request(OP_WAKE_ALL, 1'b0, 8'd0);
    repeat (5) send_request(OP_ALLOC, 1'b1, 8'd0);
    send_request(OP_FORMAT, 1'b0, 8'd0);
  endtask

  // receiver stops for a long stretch while requests keep coming
  task automatic test_output_stall();
    wait_for_results();
    write_block_count(9'd8);
    send_request(OP_FORMAT, 1'b0, 8'd0);
    sink_hold = 400;
    repeat (40) send_random_item();
  endtask

  // random traffic over a range of pool sizes, last phase without idling
  task automatic test_random_mix();
    logic [CNT_W-1:0] sizes [$];
    sizes = '{9'd2, 9'd1, 9'd0, 9'd5, 9'd16, 9'd256, 9'd511, 9'd300, 9'd3, 9'd64};
    sizes.push_back(CNT_W'($urandom_range(1, 40)));
    sizes.push_back(9'd12);
    foreach (sizes[k]) begin
      wait_for_results();
      if (k == sizes.size() - 1) steady = 1'b1;
      write_block_count(sizes[k]);
      send_request(OP_FORMAT, 1'($urandom), 8'($urandom));
      owed_allocs = 0;
      repeat (100) send_random_item();
    end
  endtask

  // receiver ready pattern in random spans, with a long hold when sink_hold is set
  initial begin
    int span;
    forever begin
      if (sink_hold > 0) begin
        span = sink_hold;
        sink_hold = 0;
        m_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        span = $urandom_range(1, 8);
        m_tready <= 1'b0;
      end else begin
        span = $urandom_range(1, 8);
        m_tready <= 1'b1;
      end
      repeat (span) @(posedge clk);
    end
  end

  // result checker: a beat seen here is taken at the next rising edge
  always @(negedge clk) begin
    res_t got;
    res_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      got.status        = m_tuser;
      got.granted_block = m_tdata[7:0];
      got.free_blocks   = m_tdata[16:8];
      got.waiters       = m_tdata[24:17];
      got.woken         = m_tdata[32:25];
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: unexpected result beat, status %0d block %0d free %0d waiters %0d",
                   $time, got.status, got.granted_block, got.free_blocks, got.waiters);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (got.status !== exp_res.status || got.granted_block !== exp_res.granted_block ||
            got.free_blocks !== exp_res.free_blocks || got.waiters !== exp_res.waiters ||
            got.woken !== exp_res.woken) begin
          if (mismatch_count < 10) begin
            $display("%0t: result mismatch", $time);
            $display("  expected status %0d block %0d free %0d waiters %0d woken %0d",
                     exp_res.status, exp_res.granted_block, exp_res.free_blocks,
                     exp_res.waiters, exp_res.woken);
            $display("  actual   status %0d block %0d free %0d waiters %0d woken %0d",
                     got.status, got.granted_block, got.free_blocks, got.waiters, got.woken);
          end
          mismatch_count++;
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_unformatted_pool();
    test_format_limits();
    test_waiter_limit();
    test_output_stall();
    test_random_mix();
    wait_for_results();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
